[src/bqeq_pkg.sv]
// bqeq_pkg: shared constants, types and helpers for the biquad cascade equalizer
// used by bqeq_div, bqeq_datapath, bqeq_ctrl and the top level
// no dependencies

package bqeq_pkg;

    localparam int CHANNELS     = 8;
    localparam int BANDS        = 8;
    localparam int FADE_STEPS   = 32;
    localparam int NCOEF        = 5;

    localparam int CH_W         = 3;
    localparam int BAND_W       = 3;
    localparam int ROW_W        = CH_W + BAND_W;
    localparam int FADE_W       = 6;
    localparam int ST_ROW_W     = 128;

    localparam int SMOOTH_SHIFT = 6;
    localparam int KNEE_LO      = 27852;
    localparam int KNEE_HI      = 55705;
    localparam int UNITY_Q15    = (1 << 15) - 1;
    localparam int KNEE_A_Q32   = -27212171;
    localparam int KNEE_B_Q32   = 565359;
    localparam int ONE_Q15      = 32768;

    // item operation codes
    typedef enum logic [2:0] {
        OP_SAMPLE     = 3'd0,
        OP_WR_COEF    = 3'd1,
        OP_SET_ACTIVE = 3'd2,
        OP_SNAP       = 3'd3,
        OP_FADE       = 3'd4
    } item_op_t;

    // datapath micro-operations
    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_PASS,
        DP_TGT_RD,
        DP_TGT_WR,
        DP_SET_ACT,
        DP_SNAP,
        DP_FADE_SET,
        DP_SMP_START,
        DP_BAND_RD,
        DP_BAND_LD,
        DP_F0,
        DP_F1,
        DP_F2,
        DP_B0,
        DP_B1,
        DP_B2,
        DP_B3,
        DP_B4,
        DP_B5,
        DP_BAND_WB,
        DP_K0,
        DP_K1,
        DP_K2,
        DP_K3,
        DP_K4,
        DP_KOUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic [BAND_W-1:0]   band;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0]          op;
        logic                coef_ok;
        logic                flat;
        logic                fade_on;
        logic [BANDS-1:0]    active;
        logic                div_busy;
    } dp_stat_t;

    typedef logic [NCOEF-1:0][31:0] coef_row_t;

    // identity biquad: b0 = 1.0, all others zero
    function automatic coef_row_t coef_identity();
        coef_row_t r;
        r    = '0;
        r[0] = 32'(ONE_Q15);
        return r;
    endfunction

endpackage

[src/bqeq_div.sv]
// bqeq_div: restoring divider for the soft knee, one quotient bit per cycle
// depends on bqeq_pkg

module bqeq_div import bqeq_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [36:0] den,
    output logic        busy,
    output logic [31:0] quo
);

    logic [5:0]  cnt_reg;
    logic [36:0] rem_reg;
    logic [36:0] den_reg;
    logic [31:0] quo_reg;
    logic [37:0] shifted;
    logic        fits;

    assign shifted = {rem_reg, 1'b0};
    assign fits    = shifted >= {1'b0, den_reg};
    assign busy    = cnt_reg != '0;
    assign quo     = quo_reg;

    // iteration counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= 6'd32;
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    // shift, compare, subtract
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {5'b0, num};
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (busy)
        begin
            rem_reg <= fits ? 37'(shifted - {1'b0, den_reg}) : shifted[36:0];
            quo_reg <= {quo_reg[30:0], fits};
        end
    end

endmodule

[src/bqeq_datapath.sv]
// bqeq_datapath: coefficient and state memories, two lane multipliers, knee logic
// depends on bqeq_pkg and bqeq_div

module bqeq_datapath import bqeq_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    input  logic [2:0]         operation,
    input  logic [2:0]         channel,
    input  logic signed [31:0] left_sample,
    input  logic signed [31:0] right_sample,
    input  logic [2:0]         band,
    input  logic [2:0]         coef_index,
    input  logic signed [31:0] coef_value,
    input  logic               band_active,
    input  logic               cfg_write,
    input  logic               bypass,
    output logic signed [15:0] left_out,
    output logic signed [15:0] right_out
);

    // latched item
    logic [2:0]          op_reg;
    logic [CH_W-1:0]     ch_reg;
    logic [BAND_W-1:0]   band_reg;
    logic [2:0]          ci_reg;
    logic [31:0]         cv_reg;
    logic                bact_reg;
    logic signed [31:0]  xin_reg [2];

    // control state
    logic                    bypass_reg;
    logic [BANDS-1:0]        act_vec_reg;
    logic [BANDS-1:0]        smooth_reg;
    logic [BANDS-1:0]        cur_vld_reg;
    logic [BANDS-1:0]        tgt_vld_reg;
    logic [CHANNELS*BANDS-1:0] st_vld_reg;
    logic [FADE_W-1:0]       fade_cnt_reg [CHANNELS];
    logic                    fade_on_reg;

    // memories and read registers
    coef_row_t               cur_mem [BANDS];
    coef_row_t               tgt_mem [BANDS];
    logic [ST_ROW_W-1:0]     st_mem [CHANNELS*BANDS];
    coef_row_t               cur_rd_reg;
    coef_row_t               tgt_rd_reg;
    logic [ST_ROW_W-1:0]     st_rd_reg;
    logic                    cur_rdv_reg;
    logic                    tgt_rdv_reg;
    logic                    st_rdv_reg;

    // lane working registers
    logic signed [31:0]  x_reg [2];
    logic signed [31:0]  t_reg [2];
    logic signed [31:0]  s1_reg [2];
    logic signed [31:0]  s2_reg [2];
    logic signed [31:0]  acc1_reg [2];
    logic signed [31:0]  acc2_reg [2];
    logic signed [31:0]  n_reg [2];
    logic signed [63:0]  p_reg [2];
    logic [15:0]         u_reg [2];
    logic                lo_reg [2];
    logic                hi_reg [2];
    logic                neg_reg [2];
    logic signed [31:0]  c_reg [NCOEF];
    logic signed [31:0]  fade_r_reg;
    logic signed [15:0]  out_reg [2];

    // combinational
    logic [BAND_W-1:0]   addr_band;
    logic [ROW_W-1:0]    st_addr;
    coef_row_t           cur_row;
    coef_row_t           tgt_row;
    coef_row_t           smooth_row;
    coef_row_t           new_tgt;
    logic [BANDS-1:0]    act_next;
    logic signed [31:0]  ma [2];
    logic signed [31:0]  mb [2];
    logic signed [63:0]  prod [2];
    logic signed [31:0]  qp [2];
    logic [32:0]         mag [2];
    logic [36:0]         den [2];
    logic                div_busy [2];
    logic [31:0]         quo [2];
    logic                div_start;

    // address select: item band for target reads and writes, sequencer band otherwise
    assign addr_band = (cmd.op == DP_TGT_RD || cmd.op == DP_TGT_WR) ? band_reg : cmd.band;
    assign st_addr   = {ch_reg, addr_band};

    assign cur_row = cur_rdv_reg ? cur_rd_reg : coef_identity();
    assign tgt_row = tgt_rdv_reg ? tgt_rd_reg : coef_identity();

    // one smoothing step toward target, snapping the residual
    always_comb
    begin
        logic signed [32:0] dif;
        logic signed [32:0] stp;
        dif = '0;
        stp = '0;
        for (int k = 0; k < NCOEF; k++)
        begin
            dif = $signed({tgt_row[k][31], tgt_row[k]}) - $signed({cur_row[k][31], cur_row[k]});
            stp = dif >>> SMOOTH_SHIFT;
            smooth_row[k] = (stp == '0) ? tgt_row[k] : 32'(cur_row[k] + stp[31:0]);
        end
    end

    // target row with one coefficient replaced
    always_comb
    begin
        for (int k = 0; k < NCOEF; k++)
        begin
            new_tgt[k] = (ci_reg == 3'(k)) ? cv_reg : tgt_row[k];
        end
    end

    always_comb
    begin
        act_next           = act_vec_reg;
        act_next[band_reg] = bact_reg;
    end

    // multiplier operand select per lane
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            case (cmd.op)
                DP_F0:   begin ma[l] = s1_reg[l];          mb[l] = fade_r_reg;       end
                DP_F1:   begin ma[l] = s2_reg[l];          mb[l] = fade_r_reg;       end
                DP_B0:   begin ma[l] = c_reg[0];           mb[l] = x_reg[l];         end
                DP_B1:   begin ma[l] = c_reg[1];           mb[l] = x_reg[l];         end
                DP_B2:   begin ma[l] = c_reg[2];           mb[l] = x_reg[l];         end
                DP_B3:   begin ma[l] = c_reg[3];           mb[l] = t_reg[l];         end
                DP_B4:   begin ma[l] = c_reg[4];           mb[l] = t_reg[l];         end
                DP_K1:   begin ma[l] = {16'b0, u_reg[l]};  mb[l] = {16'b0, u_reg[l]}; end
                DP_K2:   begin ma[l] = 32'(KNEE_A_Q32);    mb[l] = p_reg[l][31:0];   end
                DP_K3:   begin ma[l] = 32'(KNEE_B_Q32);    mb[l] = {16'b0, u_reg[l]}; end
                default: begin ma[l] = '0;                 mb[l] = '0;               end
            endcase
            prod[l] = ma[l] * mb[l];
            qp[l]   = p_reg[l][46:15];
            mag[l]  = x_reg[l][31] ? 33'(33'd0 - {x_reg[l][31], x_reg[l]}) : {1'b0, x_reg[l]};
            den[l]  = (37'd1 << 32) + p_reg[l][36:0];
        end
    end

    assign div_start = cmd.op == DP_K4;

    // knee dividers, one per lane
    for (genvar g = 0; g < 2; g++)
    begin : g_div
        bqeq_div u_div (
            .clk   (clk),
            .rst_n (rst_n),
            .start (div_start),
            .num   (n_reg[g]),
            .den   (den[g]),
            .busy  (div_busy[g]),
            .quo   (quo[g])
        );
    end

    // memories with registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_TGT_RD || cmd.op == DP_BAND_RD)
        begin
            cur_rd_reg  <= cur_mem[addr_band];
            tgt_rd_reg  <= tgt_mem[addr_band];
            st_rd_reg   <= st_mem[st_addr];
            cur_rdv_reg <= cur_vld_reg[addr_band];
            tgt_rdv_reg <= tgt_vld_reg[addr_band];
            st_rdv_reg  <= st_vld_reg[st_addr];
        end
        if (cmd.op == DP_TGT_WR)
        begin
            tgt_mem[addr_band] <= new_tgt;
        end
        if (cmd.op == DP_BAND_LD && smooth_reg[addr_band])
        begin
            cur_mem[addr_band] <= smooth_row;
        end
        if (cmd.op == DP_BAND_WB)
        begin
            st_mem[st_addr] <= {s2_reg[1], s1_reg[1], s2_reg[0], s1_reg[0]};
        end
    end

    // flags, valid bits, fade counters, bypass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_reg  <= 1'b0;
            act_vec_reg <= '0;
            smooth_reg  <= '0;
            cur_vld_reg <= '0;
            tgt_vld_reg <= '0;
            st_vld_reg  <= '0;
            fade_on_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                fade_cnt_reg[c] <= '0;
            end
        end
        else
        begin
            case (cmd.op)
                DP_SET_ACT:
                begin
                    act_vec_reg <= act_next;
                    if (bypass_reg || act_next == '0)
                    begin
                        st_vld_reg <= '0;
                    end
                end
                DP_SNAP:
                begin
                    cur_vld_reg[band_reg] <= 1'b0;
                    tgt_vld_reg[band_reg] <= 1'b0;
                    smooth_reg[band_reg]  <= 1'b0;
                end
                DP_FADE_SET:
                begin
                    fade_cnt_reg[ch_reg] <= FADE_W'(FADE_STEPS);
                end
                DP_SMP_START:
                begin
                    fade_on_reg <= fade_cnt_reg[ch_reg] != '0;
                    if (fade_cnt_reg[ch_reg] != '0)
                    begin
                        fade_cnt_reg[ch_reg] <= fade_cnt_reg[ch_reg] - FADE_W'(1);
                    end
                end
                DP_TGT_WR:
                begin
                    tgt_vld_reg[band_reg] <= 1'b1;
                    smooth_reg[band_reg]  <= new_tgt != cur_row;
                end
                DP_BAND_LD:
                begin
                    if (smooth_reg[addr_band])
                    begin
                        cur_vld_reg[addr_band] <= 1'b1;
                        smooth_reg[addr_band]  <= smooth_row != tgt_row;
                    end
                end
                DP_BAND_WB:
                begin
                    st_vld_reg[st_addr] <= 1'b1;
                end
                default:
                begin
                end
            endcase
            // bypass write; entering the flat path clears all states
            if (cfg_write)
            begin
                bypass_reg <= bypass;
                if (bypass || act_vec_reg == '0)
                begin
                    st_vld_reg <= '0;
                end
            end
        end
    end

    // soft knee result for one lane
    function automatic logic [15:0] knee_out(input int l);
        logic [32:0] v;
        logic [15:0] sat;
        v   = {1'b0, quo[l]} + 33'(KNEE_LO);
        sat = (hi_reg[l] || v > 33'(UNITY_Q15)) ? 16'(UNITY_Q15) : v[15:0];
        if (lo_reg[l])
        begin
            return x_reg[l][15:0];
        end
        return neg_reg[l] ? 16'(16'd0 - sat) : sat;
    endfunction

    // item latch and lane arithmetic
    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_LOAD)
        begin
            op_reg     <= operation;
            ch_reg     <= channel;
            band_reg   <= band;
            ci_reg     <= coef_index;
            cv_reg     <= coef_value;
            bact_reg   <= band_active;
            xin_reg[0] <= left_sample;
            xin_reg[1] <= right_sample;
        end
        if (cmd.op == DP_SMP_START)
        begin
            fade_r_reg <= 32'({fade_cnt_reg[ch_reg], 15'b0} / FADE_STEPS);
        end
        if (cmd.op == DP_BAND_LD)
        begin
            for (int k = 0; k < NCOEF; k++)
            begin
                c_reg[k] <= smooth_reg[addr_band] ? smooth_row[k] : cur_row[k];
            end
        end
        for (int l = 0; l < 2; l++)
        begin
            // each product is consumed in the next cycle
            p_reg[l] <= prod[l];
            case (cmd.op)
                DP_SMP_START: x_reg[l] <= xin_reg[l];
                DP_BAND_LD:
                begin
                    s1_reg[l] <= st_rdv_reg ? st_rd_reg[l*64 +: 32] : '0;
                    s2_reg[l] <= st_rdv_reg ? st_rd_reg[l*64+32 +: 32] : '0;
                end
                DP_F1:        s1_reg[l] <= qp[l];
                DP_F2:        s2_reg[l] <= qp[l];
                DP_B1:        t_reg[l] <= qp[l] + s1_reg[l];
                DP_B2:        acc1_reg[l] <= qp[l] + s2_reg[l];
                DP_B3:        acc2_reg[l] <= qp[l];
                DP_B4:        s1_reg[l] <= acc1_reg[l] - qp[l];
                DP_B5:
                begin
                    s2_reg[l] <= acc2_reg[l] - qp[l];
                    x_reg[l]  <= t_reg[l];
                end
                DP_K0:
                begin
                    lo_reg[l]  <= mag[l] <= 33'(KNEE_LO);
                    hi_reg[l]  <= mag[l] >= 33'(KNEE_HI);
                    neg_reg[l] <= x_reg[l][31];
                    u_reg[l]   <= 16'(mag[l] - 33'(KNEE_LO));
                end
                DP_K3:        n_reg[l] <= {16'b0, u_reg[l]} - p_reg[l][63:32];
                DP_PASS:      out_reg[l] <= xin_reg[l][15:0];
                DP_KOUT:      out_reg[l] <= knee_out(l);
                default:
                begin
                end
            endcase
        end
    end

    assign left_out  = out_reg[0];
    assign right_out = out_reg[1];

    // status to the controller
    always_comb
    begin
        stat.op       = op_reg;
        stat.coef_ok  = ci_reg < 3'(NCOEF);
        stat.flat     = bypass_reg || act_vec_reg == '0;
        stat.fade_on  = fade_on_reg;
        stat.active   = act_vec_reg;
        stat.div_busy = div_busy[0] || div_busy[1];
    end

endmodule

[src/bqeq_ctrl.sv]
// bqeq_ctrl: sequencer for the equalizer, drives datapath micro-operations
// depends on bqeq_pkg

module bqeq_ctrl import bqeq_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_stall,
    output logic     result_valid,
    input  logic     result_stall,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_TGT_RD, S_TGT_WR, S_PASS, S_START,
        S_RD, S_LD, S_F0, S_F1, S_F2,
        S_B0, S_B1, S_B2, S_B3, S_B4, S_B5, S_WB,
        S_K0, S_K1, S_K2, S_K3, S_K4, S_KWAIT, S_KOUT
    } state_t;

    state_t            state_reg, state_next;
    logic [BAND_W-1:0] band_reg, band_next;
    logic              result_valid_reg, valid_next;
    logic              out_free;

    assign out_free     = !result_valid_reg || !result_stall;
    assign item_stall   = state_reg != S_IDLE;
    assign result_valid = result_valid_reg;

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        band_next  = band_reg;
        valid_next = result_valid_reg && result_stall;
        cmd.op     = DP_NOP;
        cmd.band   = band_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                case (stat.op)
                    OP_SAMPLE:     state_next = stat.flat ? S_PASS : S_START;
                    OP_WR_COEF:    state_next = stat.coef_ok ? S_TGT_RD : S_IDLE;
                    OP_SET_ACTIVE: cmd.op = DP_SET_ACT;
                    OP_SNAP:       cmd.op = DP_SNAP;
                    OP_FADE:       cmd.op = DP_FADE_SET;
                    default:       cmd.op = DP_NOP;
                endcase
            end
            S_TGT_RD:
            begin
                cmd.op     = DP_TGT_RD;
                state_next = S_TGT_WR;
            end
            S_TGT_WR:
            begin
                cmd.op     = DP_TGT_WR;
                state_next = S_IDLE;
            end
            S_PASS:
            begin
                if (out_free)
                begin
                    cmd.op     = DP_PASS;
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_START:
            begin
                cmd.op     = DP_SMP_START;
                band_next  = '0;
                state_next = S_RD;
            end
            S_RD:
            begin
                cmd.op     = DP_BAND_RD;
                state_next = S_LD;
            end
            S_LD:
            begin
                cmd.op = DP_BAND_LD;
                if (stat.fade_on)
                begin
                    state_next = S_F0;
                end
                else
                begin
                    state_next = stat.active[band_reg] ? S_B0 : S_WB;
                end
            end
            S_F0: begin cmd.op = DP_F0; state_next = S_F1; end
            S_F1: begin cmd.op = DP_F1; state_next = S_F2; end
            S_F2:
            begin
                cmd.op     = DP_F2;
                state_next = stat.active[band_reg] ? S_B0 : S_WB;
            end
            S_B0: begin cmd.op = DP_B0; state_next = S_B1; end
            S_B1: begin cmd.op = DP_B1; state_next = S_B2; end
            S_B2: begin cmd.op = DP_B2; state_next = S_B3; end
            S_B3: begin cmd.op = DP_B3; state_next = S_B4; end
            S_B4: begin cmd.op = DP_B4; state_next = S_B5; end
            S_B5: begin cmd.op = DP_B5; state_next = S_WB; end
            S_WB:
            begin
                cmd.op = DP_BAND_WB;
                if (band_reg == BAND_W'(BANDS - 1))
                begin
                    state_next = S_K0;
                end
                else
                begin
                    band_next  = band_reg + BAND_W'(1);
                    state_next = S_RD;
                end
            end
            S_K0: begin cmd.op = DP_K0; state_next = S_K1; end
            S_K1: begin cmd.op = DP_K1; state_next = S_K2; end
            S_K2: begin cmd.op = DP_K2; state_next = S_K3; end
            S_K3: begin cmd.op = DP_K3; state_next = S_K4; end
            S_K4: begin cmd.op = DP_K4; state_next = S_KWAIT; end
            S_KWAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_KOUT;
                end
            end
            S_KOUT:
            begin
                if (out_free)
                begin
                    cmd.op     = DP_KOUT;
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            band_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            band_reg         <= band_next;
            result_valid_reg <= valid_next;
        end
    end

    // a result appears only from the passthrough or knee output step
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> ($past(state_reg) == S_PASS || $past(state_reg) == S_KOUT))
        else $error("result raised outside an output step");

    // an accepted item is decoded next
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> state_reg == S_DECODE)
        else $error("accepted item not decoded");

    // the knee starts only after the last band is written back
    a_knee_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_K0) |-> ($past(state_reg) == S_WB && $past(band_reg) == BAND_W'(BANDS - 1)))
        else $error("knee entered before the cascade finished");

    // the knee output is never formed while the divider still runs
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_KOUT) |-> !stat.div_busy)
        else $error("knee output during division");

endmodule

[src/biquad_cascade_eq_soft_knee.sv]
// Stereo eight-band Q15 biquad equalizer with per-channel state and a soft-knee
// limiter. One item is handled at a time. A sample passed through (bypass or no
// active band) is loaded, decoded and sent out. For a filtered sample each band
// has its memory read, coefficient smoothing and state write-back, fade steps
// while a fade is pending and filter steps when active, on the single multiplier
// of each lane; the knee then waits on the 32-step divider. Coefficient writes
// read and then write the target row. A result waiting on the output does not
// block the next transfer in.
// depends on bqeq_pkg, bqeq_ctrl, bqeq_datapath

module biquad_cascade_eq_soft_knee import bqeq_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [2:0]         operation,
    input  logic [2:0]         channel,
    input  logic signed [31:0] left_sample,
    input  logic signed [31:0] right_sample,
    input  logic [2:0]         band,
    input  logic [2:0]         coef_index,
    input  logic signed [31:0] coef_value,
    input  logic               band_active,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [15:0] left_out,
    output logic signed [15:0] right_out,
    input  logic               cfg_write,
    input  logic               bypass
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer
    bqeq_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .stat         (stat)
    );

    // storage and arithmetic
    bqeq_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .operation    (operation),
        .channel      (channel),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .band         (band),
        .coef_index   (coef_index),
        .coef_value   (coef_value),
        .band_active  (band_active),
        .cfg_write    (cfg_write),
        .bypass       (bypass),
        .left_out     (left_out),
        .right_out    (right_out)
    );

endmodule

[sim/tb_biquad_cascade_eq_soft_knee.sv]
// testbench for the stereo biquad cascade equalizer with soft-knee limiter
// self-checking: an in-bench predictor tracks coefficients, flags, states and fades
// depends on bqeq_pkg and biquad_cascade_eq_soft_knee

`timescale 1ns / 100ps

module tb_biquad_cascade_eq_soft_knee;
    import bqeq_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    logic [2:0]         operation;
    logic [2:0]         channel;
    logic signed [31:0] left_sample;
    logic signed [31:0] right_sample;
    logic [2:0]         band;
    logic [2:0]         coef_index;
    logic signed [31:0] coef_value;
    logic               band_active;
    logic               result_valid;
    logic               result_stall;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic               cfg_write;
    logic               bypass;

    biquad_cascade_eq_soft_knee DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .operation    (operation),
        .channel      (channel),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .band         (band),
        .coef_index   (coef_index),
        .coef_value   (coef_value),
        .band_active  (band_active),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .left_out     (left_out),
        .right_out    (right_out),
        .cfg_write    (cfg_write),
        .bypass       (bypass)
    );

    // predictor state
    logic signed [31:0] cur_coef [BANDS][NCOEF];
    logic signed [31:0] tgt_coef [BANDS][NCOEF];
    logic               smoothing [BANDS];
    logic               active [BANDS];
    logic signed [31:0] fstate [CHANNELS][BANDS][4];
    int                 fade_left [CHANNELS];
    logic               bypass_mdl;

    logic [31:0] expected_out [$];
    int          mismatches;
    int          results_seen;
    int          idle_cycles;
    int          stall_mode;
    int          burst_left;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic signed [31:0] q15_mul(logic signed [31:0] a, logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return 32'(p >>> 15);
    endfunction

    function automatic logic signed [31:0] soft_knee(logic signed [31:0] x);
        logic signed [63:0] a;
        logic signed [63:0] u;
        logic signed [63:0] n;
        logic signed [63:0] d;
        logic signed [63:0] v;
        logic signed [127:0] t;
        a = (x < 0) ? -64'(x) : 64'(x);
        if (a <= KNEE_LO)
            return x;
        if (a >= KNEE_HI)
            v = UNITY_Q15;
        else
        begin
            u = a - KNEE_LO;
            t = 128'(64'(KNEE_A_Q32)) * 128'(u * u);
            n = u - 64'(t >>> 32);
            d = 64'h1_0000_0000 + 64'(KNEE_B_Q32) * u;
            v = KNEE_LO + (n * 64'h1_0000_0000) / d;
            if (v > UNITY_Q15)
                v = UNITY_Q15;
            if (v < KNEE_LO)
                v = KNEE_LO;
        end
        return 32'((x < 0) ? -v : v);
    endfunction

    function automatic logic eq_is_flat();
        if (bypass_mdl)
            return 1'b1;
        foreach (active[b])
            if (active[b])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void clear_if_flat();
        if (eq_is_flat())
            foreach (fstate[c, b, k])
                fstate[c][b][k] = '0;
    endfunction

    function automatic logic band_settled(int b);
        for (int k = 0; k < NCOEF; k++)
            if (cur_coef[b][k] != tgt_coef[b][k])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void snap_identity(int b);
        for (int k = 0; k < NCOEF; k++)
        begin
            cur_coef[b][k] = (k == 0) ? 32'(ONE_Q15) : 32'sd0;
            tgt_coef[b][k] = cur_coef[b][k];
        end
        smoothing[b] = 1'b0;
    endfunction

    function automatic void eq_model_reset();
        for (int b = 0; b < BANDS; b++)
        begin
            snap_identity(b);
            active[b] = 1'b0;
        end
        foreach (fstate[c, b, k])
            fstate[c][b][k] = '0;
        foreach (fade_left[c])
            fade_left[c] = 0;
        bypass_mdl = 1'b0;
    endfunction

    // advance the predictor by one item, queue the output pair if any
    function automatic void eq_predict(logic [2:0] op, logic [2:0] ch, logic signed [31:0] xl_in,
                                       logic signed [31:0] xr_in, logic [2:0] bd,
                                       logic [2:0] ci, logic signed [31:0] cv, logic act);
        logic signed [31:0] xl;
        logic signed [31:0] xr;
        logic signed [31:0] tl;
        logic signed [31:0] tr;
        logic signed [31:0] r;
        logic signed [63:0] dlt;
        logic signed [63:0] st;
        xl = xl_in;
        xr = xr_in;
        case (op)
            OP_SAMPLE:
            begin
                if (!eq_is_flat() && ch < CHANNELS)
                begin
                    if (fade_left[ch] > 0)
                    begin
                        r = 32'((fade_left[ch] << 15) / FADE_STEPS);
                        fade_left[ch]--;
                        for (int b = 0; b < BANDS; b++)
                            for (int k = 0; k < 4; k++)
                                fstate[ch][b][k] = q15_mul(fstate[ch][b][k], r);
                    end
                    for (int b = 0; b < BANDS; b++)
                    begin
                        if (!smoothing[b])
                            continue;
                        for (int k = 0; k < NCOEF; k++)
                        begin
                            dlt = 64'(tgt_coef[b][k]) - 64'(cur_coef[b][k]);
                            st  = dlt >>> SMOOTH_SHIFT;
                            cur_coef[b][k] = 32'(64'(cur_coef[b][k]) + st);
                            if (st == 0)
                                cur_coef[b][k] = tgt_coef[b][k];
                        end
                        if (band_settled(b))
                            smoothing[b] = 1'b0;
                    end
                    for (int b = 0; b < BANDS; b++)
                    begin
                        if (!active[b])
                            continue;
                        tl = 32'(64'(q15_mul(cur_coef[b][0], xl)) + 64'(fstate[ch][b][0]));
                        fstate[ch][b][0] = 32'(64'(q15_mul(cur_coef[b][1], xl))
                            - 64'(q15_mul(cur_coef[b][3], tl)) + 64'(fstate[ch][b][1]));
                        fstate[ch][b][1] = 32'(64'(q15_mul(cur_coef[b][2], xl))
                            - 64'(q15_mul(cur_coef[b][4], tl)));
                        tr = 32'(64'(q15_mul(cur_coef[b][0], xr)) + 64'(fstate[ch][b][2]));
                        fstate[ch][b][2] = 32'(64'(q15_mul(cur_coef[b][1], xr))
                            - 64'(q15_mul(cur_coef[b][3], tr)) + 64'(fstate[ch][b][3]));
                        fstate[ch][b][3] = 32'(64'(q15_mul(cur_coef[b][2], xr))
                            - 64'(q15_mul(cur_coef[b][4], tr)));
                        xl = tl;
                        xr = tr;
                    end
                    xl = soft_knee(xl);
                    xr = soft_knee(xr);
                end
                expected_out.push_back({xl[15:0], xr[15:0]});
            end
            OP_WR_COEF:
                if (bd < BANDS && ci < NCOEF)
                begin
                    tgt_coef[bd][ci] = cv;
                    smoothing[bd] = !band_settled(bd);
                end
            OP_SET_ACTIVE:
                if (bd < BANDS)
                begin
                    active[bd] = act;
                    clear_if_flat();
                end
            OP_SNAP:
                if (bd < BANDS)
                    snap_identity(bd);
            OP_FADE:
                if (ch < CHANNELS)
                    fade_left[ch] = FADE_STEPS;
            default:
                ;
        endcase
    endfunction

    // result checker and output stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_mode   <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                results_seen <= results_seen + 1;
                if (expected_out.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected result: left %0d right %0d", left_out, right_out);
                end
                else
                begin
                    logic [31:0] e;
                    e = expected_out.pop_front();
                    if (left_out !== e[31:16] || right_out !== e[15:0])
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("mismatch: expected L %0d R %0d, got L %0d R %0d",
                                     $signed(e[31:16]), $signed(e[15:0]), left_out, right_out);
                    end
                end
            end
            if ((results_seen % 64) == 63)
                stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: result_stall <= 1'b0;
                1: result_stall <= ($urandom_range(0, 3) == 0);
                default: result_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    // watchdog on cycles with no transfer at either side
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding", expected_out.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // send one item, with a random gap before some bursts
    task automatic send_item(logic [2:0] op, logic [2:0] ch, logic signed [31:0] xl,
                             logic signed [31:0] xr, logic [2:0] bd, logic [2:0] ci,
                             logic signed [31:0] cv, logic act);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 1))
            begin
                item_valid <= 1'b0;
                repeat ($urandom_range(1, 40))
                    @(posedge clk);
            end
        end
        burst_left--;
        item_valid   <= 1'b1;
        operation    <= op;
        channel      <= ch;
        left_sample  <= xl;
        right_sample <= xr;
        band         <= bd;
        coef_index   <= ci;
        coef_value   <= cv;
        band_active  <= act;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        eq_predict(op, ch, xl, xr, bd, ci, cv, act);
    endtask

    task automatic send_sample(logic [2:0] ch, logic signed [31:0] xl, logic signed [31:0] xr);
        send_item(OP_SAMPLE, ch, xl, xr, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (200)
            @(posedge clk);
    endtask

    task automatic write_bypass(logic value);
        wait_drained();
        bypass    <= value;
        cfg_write <= 1'b1;
        @(posedge clk);
        cfg_write <= 1'b0;
        bypass_mdl = value;
        clear_if_flat();
    endtask

    // small signed sample: mostly audio range, sometimes full scale
    function automatic logic signed [31:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $signed($urandom_range(0, 131071)) - 65536;
            default: return $signed($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // modest coefficient so the cascade stays in range most of the time
    function automatic logic signed [31:0] rand_coef(int k);
        if ($urandom_range(0, 15) == 0)
            return $urandom;
        if (k == 0)
            return $signed($urandom_range(16384, 49152));
        return $signed($urandom_range(0, 32768)) - 16384;
    endfunction

    task automatic test_directed_passthrough();
        send_sample(0, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_sample(7, 32'sh0001_2345, -32'sd1);
        send_item(OP_SET_ACTIVE, 0, 0, 0, 3'd7, 0, 0, 1'b0);
        send_item(3'd5, 0, 0, 0, 0, 0, 0, 0);
        send_item(3'd7, 7, 0, 0, 7, 7, 32'hFFFF_FFFF, 1'b1);
        send_sample(3, 32'sd12345, -32'sd12345);
    endtask

    task automatic test_directed_filter();
        send_item(OP_SET_ACTIVE, 0, 0, 0, 3'd0, 0, 0, 1'b1);
        send_sample(1, 32'sd20000, -32'sd20000);
        send_sample(1, 32'sd40000, -32'sd40000);
        send_sample(2, 32'sd60000, 32'sh8000_0000);
        send_sample(2, 32'sh7FFF_FFFF, 32'sd27852);
        send_item(OP_WR_COEF, 0, 0, 0, 3'd0, 3'd0, 32'sd16384, 0);
        send_item(OP_WR_COEF, 0, 0, 0, 3'd0, 3'd3, 32'sh8000_0000, 0);
        send_item(OP_WR_COEF, 0, 0, 0, 3'd0, 3'd4, 32'sh7FFF_FFFF, 0);
        send_item(OP_WR_COEF, 0, 0, 0, 3'd0, 3'd5, 32'sd1, 0);
        send_sample(4, 32'sd30000, 32'sd55705);
        send_item(OP_FADE, 3'd4, 0, 0, 0, 0, 0, 0);
        send_sample(4, -32'sd30000, 32'sd1000);
        send_item(OP_SNAP, 0, 0, 0, 3'd0, 0, 0, 0);
        send_sample(4, 32'sd100, 32'sd200);
        send_item(OP_SET_ACTIVE, 0, 0, 0, 3'd0, 0, 0, 1'b0);
        send_sample(5, 32'sd100, 32'sd200);
    endtask

    task automatic test_bypass_settings();
        send_item(OP_SET_ACTIVE, 0, 0, 0, 3'd2, 0, 0, 1'b1);
        write_bypass(1'b1);
        send_sample(2, 32'sd50000, -32'sd7);
        write_bypass(1'b0);
        send_sample(2, 32'sd50000, -32'sd7);
    endtask

    // random mix, mostly samples through a configured cascade
    task automatic test_random_mix(int count);
        int kind;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 60)
                send_sample($urandom_range(0, 7), rand_sample(), rand_sample());
            else if (kind < 78)
            begin
                int k;
                k = $urandom_range(0, 4);
                send_item(OP_WR_COEF, $urandom, $urandom, $urandom,
                          $urandom_range(0, 7), k, rand_coef(k), $urandom);
            end
            else if (kind < 86)
                send_item(OP_SET_ACTIVE, $urandom, $urandom, $urandom,
                          $urandom_range(0, 7), $urandom, $urandom, ($urandom_range(0, 3) != 0));
            else if (kind < 91)
                send_item(OP_SNAP, $urandom, $urandom, $urandom,
                          $urandom_range(0, 7), $urandom, $urandom, $urandom);
            else if (kind < 96)
                send_item(OP_FADE, $urandom_range(0, 7), $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom);
            else
                send_item($urandom_range(5, 7), $urandom, $urandom, $urandom,
                          $urandom, $urandom_range(5, 7), $urandom, $urandom);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        operation    = '0;
        channel      = '0;
        left_sample  = '0;
        right_sample = '0;
        band         = '0;
        coef_index   = '0;
        coef_value   = '0;
        band_active  = 1'b0;
        cfg_write    = 1'b0;
        bypass       = 1'b0;
        mismatches   = 0;
        results_seen = 0;
        idle_cycles  = 0;
        burst_left   = 0;
        eq_model_reset();
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_passthrough();
        test_directed_filter();
        test_bypass_settings();
        test_random_mix(180);
        wait_drained();
        write_bypass(1'b1);
        test_random_mix(40);
        write_bypass(1'b0);
        test_random_mix(180);
        wait_drained();

        $display("covered %0d results across passthrough, bypass, smoothing, fade and knee",
                 results_seen);
        if (mismatches == 0)
            $display("== PASS ==");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[files.f]
src/bqeq_pkg.sv
src/bqeq_div.sv
src/bqeq_datapath.sv
src/bqeq_ctrl.sv
src/biquad_cascade_eq_soft_knee.sv
sim/tb_biquad_cascade_eq_soft_knee.sv
